[hw/rtl/fnorm_pkg.sv]
// ----------------------------------------------------------------------------
// fnorm_pkg
// Widths, lane codes and datapath types for the face normal unit.
// ----------------------------------------------------------------------------
package fnorm_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 14;

   localparam int EDGE_W = COORD_BITS + 1;                 // signed edge component
   localparam int MAG_W  = COORD_BITS;                     // |edge component|
   localparam int SQ_W   = 2 * MAG_W;                      // component squared
   localparam int NORM_W = SQ_W + 2;                       // sum of three squares
   localparam int LIM_W  = SQ_W + 2 * FRAC_BITS;           // d^2 * 2^(2F)
   localparam int Q_W    = FRAC_BITS + 1;                  // root digits b = F..0
   localparam int QN_W   = Q_W + NORM_W;                   // q * n
   localparam int CAND_W = 2 * Q_W + NORM_W;               // trial q^2 * n
   localparam int ITER   = Q_W;                            // one stage per digit
   localparam int BPOS_W = $clog2(FRAC_BITS + 1);          // digit position
   localparam int UNIT_W = Q_W + 1;                        // signed unit component
   localparam int PROD_W = 2 * UNIT_W;
   localparam int DIFF_W = PROD_W + 1;
   localparam int OUT_W  = FRAC_BITS + 2;

   localparam int LANES = 6;

   // Lane order: edge A (P3-P1) x,y,z then edge B (P2-P1) x,y,z.
   localparam int LANE_AX = 0;
   localparam int LANE_AY = 1;
   localparam int LANE_AZ = 2;
   localparam int LANE_BX = 3;
   localparam int LANE_BY = 4;
   localparam int LANE_BZ = 5;

   typedef struct packed {
      logic              neg;
      logic [NORM_W-1:0] n;
      logic [LIM_W-1:0]  lim;
      logic [LIM_W-1:0]  s;     // q^2 * n so far
      logic [QN_W-1:0]   qn;    // q * n so far
      logic [Q_W-1:0]    q;
   } lane_type;

endpackage

[hw/rtl/face_normal_from_three_points_unit.sv]
// ----------------------------------------------------------------------------
// face_normal_from_three_points_unit
// Triangle face normal: cross product of the two unit-length edges.
// ----------------------------------------------------------------------------
// Takes one beat of three signed points per clock while not stalled and returns one beat holding
// (P3-P1)/|P3-P1| x (P2-P1)/|P2-P1| with 14 fraction bits, rounded toward zero.
// A zero-length edge gives a zero normal. The datapath is a fixed pipeline of
// ITER + 5 = 20 register stages (edges, squares, norm, 15 root-digit stages,
// cross products, output); one beat per cycle is sustained while no held result
// waits on rsp_stall. rsp_stall freezes the whole pipe while rsp_valid is high; req_stall
// is high exactly while a held result waits on rsp_stall.
module face_normal_from_three_points_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p1_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p1_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p1_z,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p2_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p2_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p2_z,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p3_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p3_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0] req_p3_z,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fnorm_pkg::OUT_W-1:0]  rsp_normal_x,
   output logic signed [fnorm_pkg::OUT_W-1:0]  rsp_normal_y,
   output logic signed [fnorm_pkg::OUT_W-1:0]  rsp_normal_z
);
   import fnorm_pkg::*;

   logic en;   // whole-pipe advance

   // stage 1: edge magnitudes and signs
   logic signed [EDGE_W-1:0] edge_in [LANES];
   logic [MAG_W-1:0]         mag_ff  [LANES];
   logic                     neg_ff  [LANES];
   logic                     v1_ff;
   // stage 2: squares
   logic [SQ_W-1:0]          sq_ff   [LANES];
   logic                     neg2_ff [LANES];
   logic                     v2_ff;
   // stage 3 and root stages
   lane_type                 root    [ITER+1][LANES];
   logic                     root_v  [ITER+1];
   lane_type                 lane0_ff [LANES];
   logic                     v3_ff;
   // cross product stage
   logic signed [UNIT_W-1:0] unit    [LANES];
   logic signed [PROD_W-1:0] prod_ff [LANES];
   logic                     vp_ff;
   // output beat
   logic signed [DIFF_W-1:0] diff    [3];
   logic signed [OUT_W-1:0]  norm_in [3];
   logic signed [OUT_W-1:0]  norm_ff [3];
   logic                     rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Edge A = P3-P1, edge B = P2-P1 at full precision.
   always_comb begin
      edge_in[LANE_AX] = EDGE_W'(req_p3_x) - EDGE_W'(req_p1_x);
      edge_in[LANE_AY] = EDGE_W'(req_p3_y) - EDGE_W'(req_p1_y);
      edge_in[LANE_AZ] = EDGE_W'(req_p3_z) - EDGE_W'(req_p1_z);
      edge_in[LANE_BX] = EDGE_W'(req_p2_x) - EDGE_W'(req_p1_x);
      edge_in[LANE_BY] = EDGE_W'(req_p2_y) - EDGE_W'(req_p1_y);
      edge_in[LANE_BZ] = EDGE_W'(req_p2_z) - EDGE_W'(req_p1_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (en) begin
         for (int l = 0; l < LANES; l++) begin
            neg_ff[l]  <= edge_in[l][EDGE_W-1];
            mag_ff[l]  <= edge_in[l][EDGE_W-1] ? MAG_W'(-edge_in[l]) : MAG_W'(edge_in[l]);
            sq_ff[l]   <= SQ_W'(mag_ff[l]) * SQ_W'(mag_ff[l]);
            neg2_ff[l] <= neg_ff[l];
         end
         // squared norm per edge, limit d^2 * 2^(2F) per lane
         for (int l = 0; l < LANES; l++) begin
            lane0_ff[l].neg <= neg2_ff[l];
            lane0_ff[l].n   <= (l < 3)
               ? NORM_W'(sq_ff[LANE_AX]) + NORM_W'(sq_ff[LANE_AY]) + NORM_W'(sq_ff[LANE_AZ])
               : NORM_W'(sq_ff[LANE_BX]) + NORM_W'(sq_ff[LANE_BY]) + NORM_W'(sq_ff[LANE_BZ]);
            lane0_ff[l].lim <= LIM_W'(sq_ff[l]) << (2 * FRAC_BITS);
            lane0_ff[l].s   <= '0;
            lane0_ff[l].qn  <= '0;
            lane0_ff[l].q   <= '0;
         end
      end
   end

   assign root[0]   = lane0_ff;
   assign root_v[0] = v3_ff;

   // One stage per root digit, most significant first.
   for (genvar k = 0; k < ITER; k++) begin : g_root
      fnorm_root_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .bit_pos   (BPOS_W'(FRAC_BITS - k)),
         .in_valid  (root_v[k]),
         .in_lane   (root[k]),
         .out_valid (root_v[k+1]),
         .out_lane  (root[k+1])
      );
   end

   // Signed unit components; a zero-length edge stays zero.
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (root[ITER][l].n == '0) begin
            unit[l] = '0;
         end else if (root[ITER][l].neg) begin
            unit[l] = -$signed({1'b0, root[ITER][l].q});
         end else begin
            unit[l] = $signed({1'b0, root[ITER][l].q});
         end
      end
   end

   // Differences at 2F fraction bits, truncated toward zero to F.
   always_comb begin
      logic [DIFF_W-1:0] m;
      for (int c = 0; c < 3; c++) begin
         diff[c] = DIFF_W'(prod_ff[2*c]) - DIFF_W'(prod_ff[2*c+1]);
         m = diff[c][DIFF_W-1] ? DIFF_W'(-diff[c]) : DIFF_W'(diff[c]);
         m = m >> FRAC_BITS;
         norm_in[c] = diff[c][DIFF_W-1] ? -$signed(OUT_W'(m)) : $signed(OUT_W'(m));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vp_ff        <= root_v[ITER];
         rsp_valid_ff <= vp_ff;
      end
      if (en) begin
         prod_ff[0] <= unit[LANE_AY] * unit[LANE_BZ];
         prod_ff[1] <= unit[LANE_AZ] * unit[LANE_BY];
         prod_ff[2] <= unit[LANE_AZ] * unit[LANE_BX];
         prod_ff[3] <= unit[LANE_AX] * unit[LANE_BZ];
         prod_ff[4] <= unit[LANE_AX] * unit[LANE_BY];
         prod_ff[5] <= unit[LANE_AY] * unit[LANE_BX];
         norm_ff    <= norm_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_normal_x = norm_ff[0];
   assign rsp_normal_y = norm_ff[1];
   assign rsp_normal_z = norm_ff[2];

endmodule

[hw/rtl/fnorm_root_stage.sv]
// ----------------------------------------------------------------------------
// fnorm_root_stage
// One digit of the unit-scale search for all lanes: q = max with q^2 n <= lim.
// ----------------------------------------------------------------------------
module fnorm_root_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [fnorm_pkg::BPOS_W-1:0] bit_pos,   // tied to a constant per stage
   input  logic                       in_valid,
   input  fnorm_pkg::lane_type        in_lane  [fnorm_pkg::LANES],
   output logic                       out_valid,
   output fnorm_pkg::lane_type        out_lane [fnorm_pkg::LANES]
);
   import fnorm_pkg::*;

   lane_type lane_ff [LANES];
   lane_type lane_in [LANES];
   logic     valid_ff;

   // (q + 2^b)^2 n = q^2 n + 2^(b+1) q n + 2^(2b) n
   always_comb begin
      logic [CAND_W-1:0] cand;
      for (int l = 0; l < LANES; l++) begin
         cand = CAND_W'(in_lane[l].s)
              + (CAND_W'(in_lane[l].qn) << (bit_pos + 1))
              + (CAND_W'(in_lane[l].n) << (2 * bit_pos));
         lane_in[l] = in_lane[l];
         if (cand <= CAND_W'(in_lane[l].lim)) begin
            lane_in[l].s  = LIM_W'(cand);
            lane_in[l].qn = in_lane[l].qn + (QN_W'(in_lane[l].n) << bit_pos);
            lane_in[l].q  = in_lane[l].q | (Q_W'(1) << bit_pos);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

[hw/rtl/fnorm_checker.sv]
// ----------------------------------------------------------------------------
// fnorm_checker
// Port-level checks for the face normal unit, bound to the top level.
// ----------------------------------------------------------------------------
module fnorm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [fnorm_pkg::OUT_W-1:0]    rsp_normal_x,
   input logic signed [fnorm_pkg::OUT_W-1:0]    rsp_normal_y,
   input logic signed [fnorm_pkg::OUT_W-1:0]    rsp_normal_z
);
   import fnorm_pkg::*;

   localparam logic signed [OUT_W-1:0] ONE = OUT_W'(1) << FRAC_BITS;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid after reset");

   a_stall_only_back: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z)))
      else $error("stalled result beat changed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x <= ONE && rsp_normal_x >= -ONE
         && rsp_normal_y <= ONE && rsp_normal_y >= -ONE
         && rsp_normal_z <= ONE && rsp_normal_z >= -ONE))
      else $error("normal component beyond unit length");

endmodule

bind face_normal_from_three_points_unit fnorm_checker u_fnorm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_normal_x (rsp_normal_x),
   .rsp_normal_y (rsp_normal_y),
   .rsp_normal_z (rsp_normal_z)
);

[tb/fnorm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fnorm_scoreboard
// Watches both channels, predicts each face normal and compares it in order.
// ----------------------------------------------------------------------------
module fnorm_scoreboard (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_stall,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p1_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p1_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p1_z,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p2_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p2_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p2_z,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p3_x,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p3_y,
   input  logic signed [fnorm_pkg::COORD_BITS-1:0]  req_p3_z,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   input  logic signed [fnorm_pkg::OUT_W-1:0]       rsp_normal_x,
   input  logic signed [fnorm_pkg::OUT_W-1:0]       rsp_normal_y,
   input  logic signed [fnorm_pkg::OUT_W-1:0]       rsp_normal_z,
   output int                                       fail_count,
   output int                                       pending_normals
);
   import fnorm_pkg::*;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } normal_type;

   normal_type normal_queue[$];

   // exact unit component: largest q with q*q*n <= d*d*2^2F, sign of d
   function automatic longint unit_component(longint d, longint unsigned n);
      longint unsigned md, lim, q, t;
      if (n == 0) return 0;
      md  = d < 0 ? -d : d;
      lim = (md * md) << (2 * FRAC_BITS);
      q   = 0;
      for (int b = FRAC_BITS; b >= 0; b--) begin
         t = q | (64'd1 << b);
         if (t * t * n <= lim) q = t;
      end
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [15:0] cross_trunc(longint v);
      longint m;
      m = (v < 0 ? -v : v) >>> FRAC_BITS;
      return 16'(v < 0 ? -m : m);
   endfunction

   function automatic normal_type face_normal(longint p1[3], longint p2[3], longint p3[3]);
      longint ea[3], eb[3], ua[3], ub[3];
      longint unsigned na, nb;
      normal_type r;
      na = 0;
      nb = 0;
      for (int i = 0; i < 3; i++) begin
         ea[i] = p3[i] - p1[i];
         eb[i] = p2[i] - p1[i];
         na += ea[i] * ea[i];
         nb += eb[i] * eb[i];
      end
      for (int i = 0; i < 3; i++) begin
         ua[i] = unit_component(ea[i], na);
         ub[i] = unit_component(eb[i], nb);
      end
      r.x = cross_trunc(ua[1] * ub[2] - ua[2] * ub[1]);
      r.y = cross_trunc(ua[2] * ub[0] - ua[0] * ub[2]);
      r.z = cross_trunc(ua[0] * ub[1] - ua[1] * ub[0]);
      return r;
   endfunction

   always @(posedge clock) begin
      longint p1[3], p2[3], p3[3];
      normal_type want, got;
      if (reset) begin
         fail_count      <= 0;
         pending_normals <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            p1 = '{req_p1_x, req_p1_y, req_p1_z};
            p2 = '{req_p2_x, req_p2_y, req_p2_z};
            p3 = '{req_p3_x, req_p3_y, req_p3_z};
            normal_queue.push_back(face_normal(p1, p2, p3));
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{16'(rsp_normal_x), 16'(rsp_normal_y), 16'(rsp_normal_z)};
            if (normal_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = normal_queue.pop_front();
               if (want != got) begin
                  if (fail_count < 10)
                     $display("normal mismatch: exp %0d %0d %0d got %0d %0d %0d",
                        $signed(want.x), $signed(want.y), $signed(want.z),
                        $signed(got.x), $signed(got.y), $signed(got.z));
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_normals <= normal_queue.size();
      end
   end

endmodule

[tb/tb_face_normal_from_three_points_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_face_normal_from_three_points_unit
// Stimulus and verdict for the face normal unit.
// ----------------------------------------------------------------------------
// Drives directed triangles (extremes, coincident points, collinear points)
// then random ones in four idle/stall phases; the checker predicts and compares.
module tb_face_normal_from_three_points_unit;
   import fnorm_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [COORD_BITS-1:0] pt[9];
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   int fail_count, pending_normals;
   int idle_pct = 0, stall_pct = 0;   // per-phase chance of a gap, in percent

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   face_normal_from_three_points_unit u_dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_p1_x(pt[0]), .req_p1_y(pt[1]), .req_p1_z(pt[2]),
      .req_p2_x(pt[3]), .req_p2_y(pt[4]), .req_p2_z(pt[5]),
      .req_p3_x(pt[6]), .req_p3_y(pt[7]), .req_p3_z(pt[8]),
      .rsp_valid, .rsp_stall, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z);

   fnorm_scoreboard u_checker (
      .clock, .reset, .req_valid, .req_stall,
      .req_p1_x(pt[0]), .req_p1_y(pt[1]), .req_p1_z(pt[2]),
      .req_p2_x(pt[3]), .req_p2_y(pt[4]), .req_p2_z(pt[5]),
      .req_p3_x(pt[6]), .req_p3_y(pt[7]), .req_p3_z(pt[8]),
      .rsp_valid, .rsp_stall, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z,
      .fail_count, .pending_normals);

   initial foreach (pt[i]) pt[i] = '0;

   // receiver: random stall, redrawn every falling edge
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // one beat: optional idle gaps, then hold valid until accepted
   task automatic send_triangle(input logic signed [COORD_BITS-1:0] v[9]);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      foreach (v[i]) pt[i] <= v[i];
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // coordinate generator: full range, near the extremes, or near zero to keep edges short
   function automatic logic signed [COORD_BITS-1:0] rand_coord();
      case ($urandom_range(3))
         0: return COORD_BITS'($urandom_range(16'hFFFF));
         1: return COORD_BITS'(int'($urandom_range(15)) - 8);
         2: return $urandom_range(1) ? 16'sh7FFF - COORD_BITS'($urandom_range(3))
                                    : 16'sh8000 + COORD_BITS'($urandom_range(3));
         default: return COORD_BITS'(int'($urandom_range(511)) - 256);
      endcase
   endfunction

   task automatic random_triangle();
      logic signed [COORD_BITS-1:0] v[9];
      int kind;
      foreach (v[i]) v[i] = rand_coord();
      kind = $urandom_range(9);
      if (kind == 0) for (int i = 0; i < 3; i++) v[3 + i] = v[i];      // P2 on P1
      if (kind == 1) for (int i = 0; i < 3; i++) v[6 + i] = v[i];      // P3 on P1
      if (kind == 2) for (int i = 0; i < 3; i++)                      // P3 = P2 + (P2-P1)/2, on the line
         v[6 + i] = v[3 + i] + (v[3 + i] - v[i]) / 2;
      send_triangle(v);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_normals != 0) @(negedge clock);
   endtask

   initial begin
      logic signed [COORD_BITS-1:0] v[9];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, zero-length edges, collinear, axis triangles
      foreach (v[i]) v[i] = 0;
      send_triangle(v);                                                // all coincide
      v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
            16'sh7FFF, 16'sh8000, 16'sh7FFF};
      send_triangle(v);
      v = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
            16'sh8000, 16'sh7FFF, 16'sh8000};
      send_triangle(v);
      v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};   send_triangle(v);            // unit axes
      v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};   send_triangle(v);
      v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};   send_triangle(v);
      v = '{5, 5, 5, 5, 5, 5, 9, -3, 2};  send_triangle(v);            // P2 on P1
      v = '{5, 5, 5, 1, 2, 3, 5, 5, 5};   send_triangle(v);            // P3 on P1
      v = '{0, 0, 0, 1, 1, 1, 2, 2, 2};   send_triangle(v);            // collinear
      v = '{0, 0, 0, 1, 1, 1, -3, -3, -3}; send_triangle(v);           // antiparallel
      v = '{16'sh8000, 0, 0, 16'sh7FFF, 0, 0, 16'sh8000, 16'sh7FFF, 0};
      send_triangle(v);
      v = '{0, 0, 0, 16'sh7FFF, 1, 0, 1, 16'sh8000, 0}; send_triangle(v);
      v = '{-1, -1, -1, 0, -1, -1, -1, 0, -1}; send_triangle(v);
      v = '{16'shFFFF, 16'shAAAA, 16'h5555, 16'h5555, 16'shFFFF, 16'shAAAA,
            16'shAAAA, 16'h5555, 16'shFFFF};
      send_triangle(v);

      // Hold off until the pipe is empty at least once.
      drain();

      // random phases: free-running, sender gaps, receiver stalls, both
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 84 : (ph == 3) ? 10 : 0;
         stall_pct = (ph == 2) ? 84 : (ph == 3) ? 10 : 0;
         repeat (240) random_triangle();
      end
      drain();
      stall_pct = 0;
      repeat (40) @(negedge clock);   // latency margin

      if (fail_count == 0 && pending_normals == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog: ~1000 beats at worst-case gaps and stalls is far below this
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/fnorm_pkg.sv
hw/rtl/fnorm_root_stage.sv
hw/rtl/face_normal_from_three_points_unit.sv
hw/rtl/fnorm_checker.sv
tb/fnorm_checker.sv
tb/tb_face_normal_from_three_points_unit.sv
